// ===== rtl/gcoc_pkg.sv =====
`timescale 1ns / 1ps
package gcoc_pkg;

  localparam int GRID_DIM_MAX_DEF = 256;
  localparam int RADIUS_MAX_DEF   = 15;

  // configuration register indexes
  localparam logic [2:0] CFG_MAP_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_MAP_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_X   = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_Y   = 3'd3;
  localparam logic [2:0] CFG_CELL_SIZE  = 3'd4;
  localparam logic [2:0] CFG_RADIUS     = 3'd5;
  localparam logic [2:0] CFG_THRESHOLD  = 3'd6;

  // request kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int NUM_W = 22;

  typedef struct packed {
    logic [8:0]         map_width;
    logic [8:0]         map_height;
    logic signed [20:0] origin_x_mm;
    logic signed [20:0] origin_y_mm;
    logic [9:0]         cell_size_mm;
    logic [3:0]         radius_cells;
    logic signed [7:0]  obstacle_threshold;
  } cfg_t;

  typedef struct packed {
    logic                    is_query;
    logic                    wr_ok;
    logic [15:0]             addr;
    logic [7:0]              cost;
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic draining;
  } stat_t;

endpackage

// ===== rtl/grid_circle_obstacle_check_top.sv =====
`timescale 1ns / 1ps
// Occupancy grid disc check. The block holds a row-major grid of signed cost
// bytes and answers, for a queried world point, whether any in-map cell within
// a disc of radius_cells around that point's cell costs at least
// obstacle_threshold. A write request stores one cell and gives no result; a
// query gives exactly one result. After reset the grid memory is cleared one
// cell a cycle, during which requests are queued but not executed;
// configuration writes are taken at any time. For a query the point is turned
// into a cell by a bit-serial divider that runs once per axis, then the disc is
// swept with one read of the grid memory (one write and one read port) per
// cycle. A two-entry request queue lets new requests in while a query runs or a
// result waits.
module grid_circle_obstacle_check_top
  import gcoc_pkg::*;
#(
  parameter int GRID_DIM_MAX = GRID_DIM_MAX_DEF,
  parameter int RADIUS_MAX   = RADIUS_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [20:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] cell_index, [23:16] cell_cost, [44:24] point_x_mm,
  // [65:45] point_y_mm, [71:66] zero
  input  logic [71:0] s_axis_tdata,
  // [0] op
  input  logic [0:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] blocked, [7:1] zero
  output logic [7:0]  m_axis_tdata
);

  cfg_t  cfg_q;
  logic  cmd_valid, cmd_ready;
  cmd_t  cmd;
  logic  blocked;
  stat_t stat;

  // configuration registers; always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width          <= 9'd256;
      cfg_q.map_height         <= 9'd256;
      cfg_q.origin_x_mm        <= 21'sd0;
      cfg_q.origin_y_mm        <= 21'sd0;
      cfg_q.cell_size_mm       <= 10'd50;
      cfg_q.radius_cells       <= 4'd6;
      cfg_q.obstacle_threshold <= 8'sd50;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        CFG_MAP_WIDTH:  cfg_q.map_width          <= cfg_data_i[8:0];
        CFG_MAP_HEIGHT: cfg_q.map_height         <= cfg_data_i[8:0];
        CFG_ORIGIN_X:   cfg_q.origin_x_mm        <= $signed(cfg_data_i);
        CFG_ORIGIN_Y:   cfg_q.origin_y_mm        <= $signed(cfg_data_i);
        CFG_CELL_SIZE:  cfg_q.cell_size_mm       <= cfg_data_i[9:0];
        CFG_RADIUS:     cfg_q.radius_cells       <= cfg_data_i[3:0];
        CFG_THRESHOLD:  cfg_q.obstacle_threshold <= $signed(cfg_data_i[7:0]);
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // front: accept, classify, queue
  gcoc_front #(
    .GRID_DIM_MAX(GRID_DIM_MAX)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (s_axis_tuser[0]),
    .in_cell_index_i(s_axis_tdata[15:0]),
    .in_cell_cost_i (s_axis_tdata[23:16]),
    .in_point_x_i   ($signed(s_axis_tdata[44:24])),
    .in_point_y_i   ($signed(s_axis_tdata[65:45])),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  // back: grid memory, divider, disc sweep, result register
  gcoc_back #(
    .GRID_DIM_MAX(GRID_DIM_MAX),
    .RADIUS_MAX  (RADIUS_MAX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_blocked_o(blocked),
    .stat_o       (stat)
  );

  assign m_axis_tdata = {7'd0, blocked};

`ifndef SYNTH
  // no result may appear while the grid is still being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !m_axis_tvalid)
    else $error("result valid during grid clear");

  // a result only appears right after the sweep pipeline has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(stat.draining))
    else $error("result raised outside drain");

  // the back end takes no request while clearing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !cmd_ready)
    else $error("request taken during grid clear");
`endif

endmodule

// ===== rtl/gcoc_front.sv =====
`timescale 1ns / 1ps
module gcoc_front
  import gcoc_pkg::*;
#(
  parameter int GRID_DIM_MAX = GRID_DIM_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_op_i,
  input  logic [15:0]        in_cell_index_i,
  input  logic [7:0]         in_cell_cost_i,
  input  logic signed [20:0] in_point_x_i,
  input  logic signed [20:0] in_point_y_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output cmd_t               cmd_o
);

  localparam logic [31:0] CELLS = 32'(GRID_DIM_MAX * GRID_DIM_MAX);

  cmd_t       cmd;
  cmd_t       queue_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  // classify and precompute offsets from the origin
  always_comb begin
    cmd.is_query = (in_op_i == OP_QUERY);
    cmd.wr_ok    = ({16'b0, in_cell_index_i} < CELLS);
    cmd.addr     = in_cell_index_i;
    cmd.cost     = in_cell_cost_i;
    cmd.num_x    = $signed({in_point_x_i[20], in_point_x_i})
                 - $signed({cfg_i.origin_x_mm[20], cfg_i.origin_x_mm});
    cmd.num_y    = $signed({in_point_y_i[20], in_point_y_i})
                 - $signed({cfg_i.origin_y_mm[20], cfg_i.origin_y_mm});
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/gcoc_div.sv =====
`timescale 1ns / 1ps
module gcoc_div
  import gcoc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [9:0]              den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quot_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] work_q;
  logic [9:0]       rem_q;
  logic [9:0]       den_q;
  logic             sign_q, busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [10:0]      trial;
  logic             fits;

  // one quotient bit per cycle, restoring on the magnitude
  assign trial = {rem_q, work_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      rem_q  <= 10'd0;
      den_q  <= den_i;
      sign_q <= num_i[NUM_W-1];
    end else if (busy_q) begin
      work_q <= {work_q[NUM_W-2:0], fits};
      rem_q  <= fits ? 10'(trial - {1'b0, den_q}) : trial[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = sign_q ? $signed(-work_q) : $signed(work_q);

endmodule

// ===== rtl/gcoc_back.sv =====
`timescale 1ns / 1ps
module gcoc_back
  import gcoc_pkg::*;
#(
  parameter int GRID_DIM_MAX = GRID_DIM_MAX_DEF,
  parameter int RADIUS_MAX   = RADIUS_MAX_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  cmd_valid_i,
  output logic  cmd_ready_o,
  input  cmd_t  cmd_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  out_blocked_o,
  output stat_t stat_o
);

  localparam int CELLS = GRID_DIM_MAX * GRID_DIM_MAX;
  localparam int AW    = $clog2(CELLS);
  localparam int LW    = $clog2(GRID_DIM_MAX);
  localparam int DW    = LW + 1;
  localparam int PW    = LW + DW;
  localparam int RW    = $clog2(RADIUS_MAX + 1);
  localparam int SQW   = 2 * RW + 3;
  localparam int CXW   = NUM_W + 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIVX  = 3'd2;
  localparam logic [2:0] ST_DIVY  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [AW-1:0] clr_q;

  logic [7:0]  mem [CELLS];
  logic        we;
  logic [AW-1:0] wa;
  logic [7:0]  wd;

  logic [DW-1:0] w_eff, h_eff;
  logic [9:0]    cs_eff;
  logic [RW-1:0] r_eff;
  logic signed [RW:0] rs;

  logic        div_start, div_done;
  logic signed [NUM_W-1:0] div_num, div_quot, num_y_q;
  logic signed [NUM_W-1:0] cx_q, cy_q;
  logic signed [RW:0] dx_q, dy_q;
  logic        last;

  logic signed [CXW-1:0] x0, y0;
  logic signed [SQW-1:0] dx_w, dy_w;
  logic [SQW-1:0] d2, r2;
  logic        take0;
  logic        v1_q, v2_q, v3_q;
  logic [LW-1:0] x1_q, y1_q;
  logic [AW-1:0] addr2_q;
  logic [7:0]  rdata_q;
  logic        hit_q;
  logic        out_valid_q, out_blocked_q;
  logic        is_write, is_query;

  assign w_eff  = (32'(cfg_i.map_width) > GRID_DIM_MAX) ? DW'(GRID_DIM_MAX)
                                                        : DW'(cfg_i.map_width);
  assign h_eff  = (32'(cfg_i.map_height) > GRID_DIM_MAX) ? DW'(GRID_DIM_MAX)
                                                         : DW'(cfg_i.map_height);
  assign cs_eff = (cfg_i.cell_size_mm == 10'd0) ? 10'd1 : cfg_i.cell_size_mm;
  assign r_eff  = (32'(cfg_i.radius_cells) > RADIUS_MAX) ? RW'(RADIUS_MAX)
                                                         : RW'(cfg_i.radius_cells);
  assign rs     = $signed((RW + 1)'(r_eff));

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign is_write    = cmd_valid_i && cmd_ready_o && !cmd_i.is_query;
  assign is_query    = cmd_valid_i && cmd_ready_o && cmd_i.is_query;

  // shared divider: x first, then y
  assign div_start = is_query || ((state_q == ST_DIVX) && div_done);
  assign div_num   = (state_q == ST_DIVX) ? num_y_q : cmd_i.num_x;

  gcoc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (cs_eff),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // grid memory: one write and one read port
  assign we = (state_q == ST_CLEAR) || (is_write && cmd_i.wr_ok);
  assign wa = (state_q == ST_CLEAR) ? clr_q : AW'(cmd_i.addr);
  assign wd = (state_q == ST_CLEAR) ? 8'd0 : cmd_i.cost;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rdata_q <= mem[addr2_q];
  end

  // candidate cell of the disc scan
  assign x0    = $signed(CXW'(cx_q)) + $signed(CXW'(dx_q));
  assign y0    = $signed(CXW'(cy_q)) + $signed(CXW'(dy_q));
  assign dx_w  = SQW'(dx_q);
  assign dy_w  = SQW'(dy_q);
  assign d2    = SQW'(dx_w * dx_w + dy_w * dy_w);
  assign r2    = SQW'(r_eff) * SQW'(r_eff);
  assign last  = (dx_q == rs) && (dy_q == rs);
  assign take0 = (state_q == ST_SCAN) && (d2 <= r2)
               && !x0[CXW-1] && (x0 < $signed(CXW'(w_eff)))
               && !y0[CXW-1] && (y0 < $signed(CXW'(h_eff)));

  always_ff @(posedge clk_i) begin
    x1_q    <= x0[LW-1:0];
    y1_q    <= y0[LW-1:0];
    addr2_q <= AW'(PW'(y1_q) * PW'(w_eff) + PW'(x1_q));
    if (is_query) num_y_q <= cmd_i.num_y;
    if ((state_q == ST_DIVX) && div_done) cx_q <= div_quot;
    if ((state_q == ST_DIVY) && div_done) cy_q <= div_quot;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AW'(CELLS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (is_query) state_d = ST_DIVX;
      ST_DIVX:  if (div_done) state_d = ST_DIVY;
      ST_DIVY:  if (div_done) state_d = ST_SCAN;
      ST_SCAN:  if (last) state_d = ST_DRAIN;
      ST_DRAIN: if (!v1_q && !v2_q && !v3_q && !out_valid_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      dx_q          <= '0;
      dy_q          <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      v3_q          <= 1'b0;
      hit_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      out_blocked_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      v1_q <= take0;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if ((state_q == ST_DIVY) && div_done) begin
        dx_q  <= -rs;
        dy_q  <= -rs;
        hit_q <= 1'b0;
      end else begin
        if (state_q == ST_SCAN) begin
          if (dy_q == rs) begin
            dy_q <= -rs;
            dx_q <= dx_q + 1'b1;
          end else begin
            dy_q <= dy_q + 1'b1;
          end
        end
        if (v3_q && ($signed(rdata_q) >= cfg_i.obstacle_threshold)) hit_q <= 1'b1;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if ((state_q == ST_DRAIN) && (state_d == ST_IDLE)) begin
        out_valid_q   <= 1'b1;
        out_blocked_q <= hit_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_blocked_o   = out_blocked_q;
  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign stat_o.draining = (state_q == ST_DRAIN);

endmodule
